>>> sv/acl_pkg.sv
package acl_pkg;

  // Port widths of the command and result fields
  localparam int unsigned COORD_W = 6;
  localparam int unsigned COVER_W = 9;

  // Defaults for the top-level parameters
  localparam int unsigned COORD_BITS_DEF = 6;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned COVER_BITS_DEF = 8;

  // Width of one classified line record:
  // {steep, down, a0, b0, a1, b1, da, db}
  function automatic int unsigned setup_width(input int unsigned coord_bits);
    return 6 * coord_bits + 2;
  endfunction

endpackage

>>> sv/antialiased_line_rasterizer.sv
// Antialiased line rasterizer (Wu's scheme). Each line item on the input
// channel yields one pixel-pair result per major-axis column: the first
// endpoint column, the second endpoint column, then the interior columns in
// ascending order, with last set on the final one. The gradient divider
// produces one quotient bit per cycle while the endpoint columns go out,
// and the interior columns wait for it to finish; the column walker then
// gives one result per cycle while the result side does not stall. The
// front end classifies the next line and a two-entry queue holds classified
// lines, so up to three lines may be accepted while the back end is busy.
module antialiased_line_rasterizer #(
  parameter int unsigned COORD_BITS = acl_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = acl_pkg::FRAC_BITS_DEF,
  parameter int unsigned COVER_BITS = acl_pkg::COVER_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [acl_pkg::COORD_W-1:0] start_x_i,
  input  logic [acl_pkg::COORD_W-1:0] start_y_i,
  input  logic [acl_pkg::COORD_W-1:0] end_x_i,
  input  logic [acl_pkg::COORD_W-1:0] end_y_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [acl_pkg::COORD_W-1:0] pixel_x_o,
  output logic [acl_pkg::COORD_W-1:0] pixel_y_o,
  output logic                        pair_axis_o,
  output logic [acl_pkg::COVER_W-1:0] cover_first_o,
  output logic [acl_pkg::COVER_W-1:0] cover_second_o,
  output logic                        last_o
);

  localparam int unsigned SetupW = acl_pkg::setup_width(COORD_BITS);

  logic              fr_valid, fr_ready;
  logic [SetupW-1:0] fr_data;
  logic              q_valid, q_ready;
  logic [SetupW-1:0] q_data;

  acl_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .setup_valid_o(fr_valid),
    .setup_ready_i(fr_ready),
    .setup_o      (fr_data)
  );

  acl_fifo #(
    .WIDTH(SetupW)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fr_valid),
    .wr_ready_o(fr_ready),
    .wr_data_i (fr_data),
    .rd_valid_o(q_valid),
    .rd_ready_i(q_ready),
    .rd_data_o (q_data)
  );

  acl_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .COVER_BITS(COVER_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .setup_valid_i (q_valid),
    .setup_ready_o (q_ready),
    .setup_i       (q_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pair_axis_o   (pair_axis_o),
    .cover_first_o (cover_first_o),
    .cover_second_o(cover_second_o),
    .last_o        (last_o)
  );

endmodule

>>> sv/acl_front.sv
module acl_front #(
  parameter int unsigned COORD_BITS = acl_pkg::COORD_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic [acl_pkg::COORD_W-1:0]                start_x_i,
  input  logic [acl_pkg::COORD_W-1:0]                start_y_i,
  input  logic [acl_pkg::COORD_W-1:0]                end_x_i,
  input  logic [acl_pkg::COORD_W-1:0]                end_y_i,
  output logic                                       setup_valid_o,
  input  logic                                       setup_ready_i,
  output logic [acl_pkg::setup_width(COORD_BITS)-1:0] setup_o
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned SetupW = acl_pkg::setup_width(COORD_BITS);

  logic [C-1:0] x0, y0, x1, y1;
  logic [C-1:0] adx, ady;
  logic         steep;
  logic [C-1:0] pa0, pb0, pa1, pb1;
  logic [C-1:0] a0, b0, a1, b1;
  logic [C-1:0] da, db;
  logic         down;
  logic         valid_q;
  logic [SetupW-1:0] setup_q;
  logic         load;

  // Use only the low coordinate bits
  assign x0 = start_x_i[C-1:0];
  assign y0 = start_y_i[C-1:0];
  assign x1 = end_x_i[C-1:0];
  assign y1 = end_y_i[C-1:0];

  // Classify: steepness, axis swap, endpoint order, deltas
  always_comb begin
    adx   = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady   = (y1 > y0) ? y1 - y0 : y0 - y1;
    steep = ady > adx;
    pa0   = steep ? y0 : x0;
    pb0   = steep ? x0 : y0;
    pa1   = steep ? y1 : x1;
    pb1   = steep ? x1 : y1;
    if (pa0 > pa1) begin
      a0 = pa1;
      b0 = pb1;
      a1 = pa0;
      b1 = pb0;
    end else begin
      a0 = pa0;
      b0 = pb0;
      a1 = pa1;
      b1 = pb1;
    end
    da   = a1 - a0;
    down = b1 < b0;
    db   = down ? b0 - b1 : b1 - b0;
  end

  // Hold one classified item until the queue takes it
  assign in_ready_o    = !valid_q || setup_ready_i;
  assign load          = in_valid_i && in_ready_o;
  assign setup_valid_o = valid_q;
  assign setup_o       = setup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      setup_q <= {steep, down, a0, b0, a1, b1, da, db};
    end
  end

endmodule

>>> sv/acl_fifo.sv
module acl_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic [1:0]       count_d;
  logic             push;
  logic             pop;

  assign wr_ready_o = count_q != 2'd2;
  assign rd_valid_o = count_q != 2'd0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> sv/acl_back.sv
module acl_back #(
  parameter int unsigned COORD_BITS = acl_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = acl_pkg::FRAC_BITS_DEF,
  parameter int unsigned COVER_BITS = acl_pkg::COVER_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       setup_valid_i,
  output logic                                       setup_ready_o,
  input  logic [acl_pkg::setup_width(COORD_BITS)-1:0] setup_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic [acl_pkg::COORD_W-1:0]                pixel_x_o,
  output logic [acl_pkg::COORD_W-1:0]                pixel_y_o,
  output logic                                       pair_axis_o,
  output logic [acl_pkg::COVER_W-1:0]                cover_first_o,
  output logic [acl_pkg::COVER_W-1:0]                cover_second_o,
  output logic                                       last_o
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned V     = COVER_BITS;
  localparam int unsigned IcW   = C + F;
  localparam int unsigned CntW  = $clog2(F + 2);
  localparam int unsigned UpSh  = (V > F) ? V - F : 0;
  localparam int unsigned DnSh  = (F > V) ? F - V : 0;
  localparam int unsigned WideW = V + F;
  localparam int unsigned PixW  = acl_pkg::COORD_W;
  localparam int unsigned CovW  = acl_pkg::COVER_W;
  localparam logic [V:0]  CoverOne  = (V + 1)'(1) << V;
  localparam logic [V:0]  CoverHalf = (V + 1)'(1) << (V - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_END0,
    S_END1,
    S_INTR
  } state_e;

  // Unpacked queue record
  logic         in_steep, in_down;
  logic [C-1:0] in_a0, in_b0, in_a1, in_b1, in_da, in_db;

  assign {in_steep, in_down, in_a0, in_b0, in_a1, in_b1, in_da, in_db} = setup_i;

  // Gradient divider: restoring, one quotient bit per cycle
  logic [C:0]      rem_q, rem_d;
  logic [F:0]      quo_q, quo_d;
  logic [CntW-1:0] dcnt_q, dcnt_d;
  logic            div_done;
  logic            div_ge;
  logic [C:0]      div_sub;

  // Line walker
  state_e       state_q, state_d;
  logic         steep_q, down_q;
  logic [C-1:0] a0_q, b0_q, a1_q, b1_q, da_q, maj_q;
  logic [C-1:0] maj_d;
  logic [IcW-1:0] ic_q, ic_d;
  logic [IcW-1:0] ic_step;
  logic [F-1:0] frac;
  logic [WideW-1:0] frac_wide;
  logic [V-1:0] c2;
  logic [V:0]   c1;
  logic         take;
  logic         slot_free;

  // Output register
  logic         out_valid_q, out_valid_d;
  logic [C-1:0] major_q, major_d, minor_q, minor_d;
  logic         axis_q, axis_d;
  logic [V:0]   cf_q, cf_d, cs_q, cs_d;
  logic         last_q, last_d;

  assign setup_ready_o = state_q == S_IDLE;
  assign take          = setup_valid_i && setup_ready_o;
  assign slot_free     = !out_valid_q || out_ready_i;
  assign div_done      = dcnt_q == '0;

  // Divider step
  always_comb begin
    div_ge  = rem_q >= {1'b0, da_q};
    div_sub = div_ge ? rem_q - {1'b0, da_q} : rem_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dcnt_d  = dcnt_q;
    if (take) begin
      rem_d  = {1'b0, in_db};
      quo_d  = '0;
      dcnt_d = CntW'(F + 1);
    end else if (!div_done) begin
      rem_d  = {div_sub[C-1:0], 1'b0};
      quo_d  = {quo_q[F-1:0], div_ge};
      dcnt_d = dcnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else begin
      dcnt_q <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // Next intercept and its coverage split
  always_comb begin
    ic_step   = down_q ? ic_q - IcW'(quo_q) : ic_q + IcW'(quo_q);
    frac      = ic_step[F-1:0];
    frac_wide = (WideW'(frac) << UpSh) >> DnSh;
    c2        = frac_wide[V-1:0];
    c1        = CoverOne - (V + 1)'(c2);
  end

  // Walk the line: endpoint columns, then interior columns
  always_comb begin
    state_d     = state_q;
    maj_d       = maj_q;
    ic_d        = ic_q;
    out_valid_d = out_valid_q && !out_ready_i;
    major_d     = major_q;
    minor_d     = minor_q;
    axis_d      = axis_q;
    cf_d        = cf_q;
    cs_d        = cs_q;
    last_d      = last_q;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = S_END0;
          maj_d   = in_a0 + C'(1);
          ic_d    = {in_b0, {F{1'b0}}};
        end
      end
      S_END0: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          major_d     = a0_q;
          minor_d     = b0_q;
          axis_d      = steep_q;
          cf_d        = CoverHalf;
          cs_d        = '0;
          last_d      = da_q == '0;
          state_d     = (da_q == '0) ? S_IDLE : S_END1;
        end
      end
      S_END1: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          major_d     = a1_q;
          minor_d     = b1_q;
          axis_d      = steep_q;
          cf_d        = CoverHalf;
          cs_d        = '0;
          last_d      = da_q == C'(1);
          state_d     = (da_q == C'(1)) ? S_IDLE : S_INTR;
        end
      end
      S_INTR: begin
        if (slot_free && div_done) begin
          out_valid_d = 1'b1;
          major_d     = maj_q;
          minor_d     = ic_step[IcW-1:F];
          axis_d      = steep_q;
          cf_d        = c1;
          cs_d        = (V + 1)'(c2);
          last_d      = (maj_q + C'(1)) == a1_q;
          ic_d        = ic_step;
          maj_d       = maj_q + C'(1);
          if ((maj_q + C'(1)) == a1_q) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold walker state, the line record and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      maj_q       <= '0;
      ic_q        <= '0;
      major_q     <= '0;
      minor_q     <= '0;
      axis_q      <= 1'b0;
      cf_q        <= '0;
      cs_q        <= '0;
      last_q      <= 1'b0;
      steep_q     <= 1'b0;
      down_q      <= 1'b0;
      a0_q        <= '0;
      b0_q        <= '0;
      a1_q        <= '0;
      b1_q        <= '0;
      da_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      maj_q       <= maj_d;
      ic_q        <= ic_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      axis_q      <= axis_d;
      cf_q        <= cf_d;
      cs_q        <= cs_d;
      last_q      <= last_d;
      if (take) begin
        steep_q <= in_steep;
        down_q  <= in_down;
        a0_q    <= in_a0;
        b0_q    <= in_b0;
        a1_q    <= in_a1;
        b1_q    <= in_b1;
        da_q    <= in_da;
      end
    end
  end

  // Map major/minor back to screen axes
  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = axis_q ? PixW'(minor_q) : PixW'(major_q);
  assign pixel_y_o      = axis_q ? PixW'(major_q) : PixW'(minor_q);
  assign pair_axis_o    = axis_q;
  assign cover_first_o  = CovW'(cf_q);
  assign cover_second_o = CovW'(cs_q);
  assign last_o         = last_q;

endmodule

>>> sv/acl_checker.sv
module acl_checker #(
  parameter int unsigned COVER_BITS = acl_pkg::COVER_BITS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [acl_pkg::COORD_W-1:0] start_x_i,
  input logic [acl_pkg::COORD_W-1:0] start_y_i,
  input logic [acl_pkg::COORD_W-1:0] end_x_i,
  input logic [acl_pkg::COORD_W-1:0] end_y_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [acl_pkg::COORD_W-1:0] pixel_x_o,
  input logic [acl_pkg::COORD_W-1:0] pixel_y_o,
  input logic                        pair_axis_o,
  input logic [acl_pkg::COVER_W-1:0] cover_first_o,
  input logic [acl_pkg::COVER_W-1:0] cover_second_o,
  input logic                        last_o
);

  localparam int unsigned CovW = acl_pkg::COVER_W;
  localparam logic [CovW-1:0] One  = CovW'(64'd1 << COVER_BITS);
  localparam logic [CovW-1:0] Half = CovW'(64'd1 << (COVER_BITS - 1));

  logic [CovW-1:0] cover_sum;

  assign cover_sum = cover_first_o + cover_second_o;

  // Hold a waiting line item
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(start_x_i) &&
      $stable(start_y_i) && $stable(end_x_i) && $stable(end_y_i))
    else $error("line item changed while waiting");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_x_o) &&
      $stable(pixel_y_o) && $stable(pair_axis_o) && $stable(cover_first_o) &&
      $stable(cover_second_o) && $stable(last_o))
    else $error("result changed while stalled");

  // Coverages sum to one, except on an endpoint column
  a_cover_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cover_sum == One ||
      (cover_first_o == Half && cover_second_o == '0))
    else $error("coverage pair does not sum to one");

  // A zero second coverage pairs with a full or half first coverage
  a_cover_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cover_second_o == '0 |-> cover_first_o == One ||
      cover_first_o == Half)
    else $error("bad first coverage with empty second pixel");

endmodule

bind antialiased_line_rasterizer acl_checker #(
  .COVER_BITS(COVER_BITS)
) u_acl_checker (.*);

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [acl_pkg::COORD_W-1:0] coord_t;
  typedef logic [acl_pkg::COVER_W-1:0] cover_t;

  // One pixel-pair write as it leaves the block
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   pair_axis;
    cover_t cover_first;
    cover_t cover_second;
    logic   last;
  } pair_write_t;

  // One directed line, with up to two writes typed in by hand
  typedef struct packed {
    coord_t      sx;
    coord_t      sy;
    coord_t      ex;
    coord_t      ey;
    logic [1:0]  n_typed;
    pair_write_t typed0;
    pair_write_t typed1;
  } line_row_t;

  localparam int unsigned COORD_BITS = acl_pkg::COORD_BITS_DEF;
  localparam int unsigned FRAC_BITS  = acl_pkg::FRAC_BITS_DEF;
  localparam int unsigned COVER_BITS = acl_pkg::COVER_BITS_DEF;

  localparam logic AXIS_Y_NEXT = 1'b0;
  localparam logic AXIS_X_NEXT = 1'b1;

  localparam int          COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam longint unsigned FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;
  localparam longint unsigned COVER_ONE = 64'd1 << COVER_BITS;
  localparam cover_t      HALF        = cover_t'(1 << (COVER_BITS - 1));
  localparam int unsigned UP_SH = (COVER_BITS > FRAC_BITS) ? COVER_BITS - FRAC_BITS : 0;
  localparam int unsigned DN_SH = (FRAC_BITS > COVER_BITS) ? FRAC_BITS - COVER_BITS : 0;

  localparam int unsigned RANDOM_LINES = 430;
  localparam int unsigned CALM_LINES   = 60;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;

  localparam pair_write_t NONE = '0;

  localparam line_row_t DIRECTED [25] = '{
    // degenerate lines: one write, half coverage, last set
    '{6'd5,  6'd9,  6'd5,  6'd9,  2'd1, '{6'd5,  6'd9,  AXIS_Y_NEXT, HALF, 9'd0, 1'b1}, NONE},
    '{6'd0,  6'd0,  6'd0,  6'd0,  2'd1, '{6'd0,  6'd0,  AXIS_Y_NEXT, HALF, 9'd0, 1'b1}, NONE},
    '{6'd63, 6'd63, 6'd63, 6'd63, 2'd1, '{6'd63, 6'd63, AXIS_Y_NEXT, HALF, 9'd0, 1'b1}, NONE},
    // one column apart: two endpoint writes only
    '{6'd10, 6'd20, 6'd11, 6'd20, 2'd2,
      '{6'd10, 6'd20, AXIS_Y_NEXT, HALF, 9'd0, 1'b0},
      '{6'd11, 6'd20, AXIS_Y_NEXT, HALF, 9'd0, 1'b1}},
    '{6'd7,  6'd30, 6'd7,  6'd31, 2'd2,
      '{6'd7,  6'd30, AXIS_X_NEXT, HALF, 9'd0, 1'b0},
      '{6'd7,  6'd31, AXIS_X_NEXT, HALF, 9'd0, 1'b1}},
    '{6'd40, 6'd3,  6'd39, 6'd3,  2'd2,
      '{6'd39, 6'd3,  AXIS_Y_NEXT, HALF, 9'd0, 1'b0},
      '{6'd40, 6'd3,  AXIS_Y_NEXT, HALF, 9'd0, 1'b1}},
    // equal deltas stay shallow
    '{6'd2,  6'd2,  6'd3,  6'd3,  2'd2,
      '{6'd2,  6'd2,  AXIS_Y_NEXT, HALF, 9'd0, 1'b0},
      '{6'd3,  6'd3,  AXIS_Y_NEXT, HALF, 9'd0, 1'b1}},
    '{6'd63, 6'd0,  6'd62, 6'd1,  2'd2,
      '{6'd62, 6'd1,  AXIS_Y_NEXT, HALF, 9'd0, 1'b0},
      '{6'd63, 6'd0,  AXIS_Y_NEXT, HALF, 9'd0, 1'b1}},
    // full-screen and mixed lines, checked by the predictor
    '{6'd0,  6'd0,  6'd63, 6'd0,  2'd0, NONE, NONE},
    '{6'd63, 6'd0,  6'd0,  6'd0,  2'd0, NONE, NONE},
    '{6'd0,  6'd0,  6'd0,  6'd63, 2'd0, NONE, NONE},
    '{6'd0,  6'd63, 6'd0,  6'd0,  2'd0, NONE, NONE},
    '{6'd0,  6'd0,  6'd63, 6'd63, 2'd0, NONE, NONE},
    '{6'd63, 6'd63, 6'd0,  6'd0,  2'd0, NONE, NONE},
    '{6'd63, 6'd0,  6'd0,  6'd63, 2'd0, NONE, NONE},
    '{6'd0,  6'd63, 6'd63, 6'd62, 2'd0, NONE, NONE},
    '{6'd0,  6'd0,  6'd63, 6'd1,  2'd0, NONE, NONE},
    '{6'd63, 6'd0,  6'd62, 6'd63, 2'd0, NONE, NONE},
    '{6'd0,  6'd0,  6'd1,  6'd63, 2'd0, NONE, NONE},
    '{6'd10, 6'd5,  6'd50, 6'd30, 2'd0, NONE, NONE},
    '{6'd50, 6'd30, 6'd10, 6'd5,  2'd0, NONE, NONE},
    '{6'd20, 6'd40, 6'd25, 6'd10, 2'd0, NONE, NONE},
    '{6'd21, 6'd42, 6'd42, 6'd21, 2'd0, NONE, NONE},
    '{6'd0,  6'd0,  6'd2,  6'd1,  2'd0, NONE, NONE},
    '{6'd0,  6'd0,  6'd3,  6'd2,  2'd0, NONE, NONE}
  };

  logic   clk_i          = 1'b0;
  logic   rst_ni         = 1'b0;
  logic   in_valid_i     = 1'b0;
  coord_t start_x_i      = '0;
  coord_t start_y_i      = '0;
  coord_t end_x_i        = '0;
  coord_t end_y_i        = '0;
  logic   out_ready_i    = 1'b0;
  logic   in_ready_o;
  logic   out_valid_o;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  logic   pair_axis_o;
  cover_t cover_first_o;
  cover_t cover_second_o;
  logic   last_o;

  pair_write_t expected_writes[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;

  antialiased_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .COVER_BITS(COVER_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pair_axis_o   (pair_axis_o),
    .cover_first_o (cover_first_o),
    .cover_second_o(cover_second_o),
    .last_o        (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic pair_write_t make_write(coord_t major, coord_t minor, logic steep,
                                             cover_t c1, cover_t c2, logic last);
    pair_write_t w;
    w.pixel_x      = steep ? minor : major;
    w.pixel_y      = steep ? major : minor;
    w.pair_axis    = steep ? AXIS_X_NEXT : AXIS_Y_NEXT;
    w.cover_first  = c1;
    w.cover_second = c2;
    w.last         = last;
    return w;
  endfunction

  // Queue the column writes that one line produces, in emission order
  function automatic void predict_line_writes(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    coord_t          a0, b0, a1, b1, swap;
    logic            steep, down;
    int unsigned     adx, ady, da, db;
    longint unsigned mag, base, isect, frac, c2;
    adx   = (ex > sx) ? int'(ex - sx) : int'(sx - ex);
    ady   = (ey > sy) ? int'(ey - sy) : int'(sy - ey);
    steep = ady > adx;
    a0 = steep ? sy : sx;
    b0 = steep ? sx : sy;
    a1 = steep ? ey : ex;
    b1 = steep ? ex : ey;
    if (a0 > a1) begin
      swap = a0; a0 = a1; a1 = swap;
      swap = b0; b0 = b1; b1 = swap;
    end
    da = int'(a1) - int'(a0);
    if (da == 0) begin
      expected_writes.push_back(make_write(a0, b0, steep, HALF, '0, 1'b1));
      return;
    end
    expected_writes.push_back(make_write(a0, b0, steep, HALF, '0, 1'b0));
    expected_writes.push_back(make_write(a1, b1, steep, HALF, '0, da == 1));
    down = b1 < b0;
    db   = down ? int'(b0) - int'(b1) : int'(b1) - int'(b0);
    mag  = (longint'(db) << FRAC_BITS) / da;
    base = longint'(b0) << FRAC_BITS;
    // Walk the interior columns, stepping the intercept by the truncated gradient
    for (int unsigned k = 1; k < da; k++) begin
      isect = down ? base - k * mag : base + k * mag;
      frac  = isect & FRAC_MASK;
      c2    = (frac << UP_SH) >> DN_SH;
      expected_writes.push_back(make_write(coord_t'(a0 + k), coord_t'(isect >> FRAC_BITS),
                                           steep, cover_t'(COVER_ONE - c2), cover_t'(c2),
                                           k + 1 == da));
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  // Compare each accepted write with the oldest expectation
  always @(posedge clk_i) begin
    pair_write_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_writes.size() == 0) begin
        $display("%0t: write (%0d,%0d) with no line pending, expected none",
                 $time, pixel_x_o, pixel_y_o);
        mismatches++;
      end else begin
        want = expected_writes.pop_front();
        check_field("pixel_x", want.pixel_x, pixel_x_o);
        check_field("pixel_y", want.pixel_y, pixel_y_o);
        check_field("pair_axis", want.pair_axis, pair_axis_o);
        check_field("cover_first", want.cover_first, cover_first_o);
        check_field("cover_second", want.cover_second, cover_second_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  // Stall the result side in random bursts, never once the run is calm
  initial begin
    wait (rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  task automatic drive_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    in_valid_i <= 1'b1;
    start_x_i  <= sx;
    start_y_i  <= sy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic drain_writes();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_writes.size() != 0) @(posedge clk_i);
  endtask

  // Pick a line: random, short, degenerate, near-diagonal, or snapped to screen edges
  task automatic pick_line(output coord_t sx, output coord_t sy,
                           output coord_t ex, output coord_t ey);
    int unsigned mode;
    int          d;
    mode = $urandom_range(0, 99);
    sx = coord_t'($urandom_range(0, COORD_MAX));
    sy = coord_t'($urandom_range(0, COORD_MAX));
    ex = coord_t'($urandom_range(0, COORD_MAX));
    ey = coord_t'($urandom_range(0, COORD_MAX));
    if (mode >= 35 && mode < 75) begin
      ex = clamp_coord(int'(sx) + int'($urandom_range(0, 10)) - 5);
      ey = clamp_coord(int'(sy) + int'($urandom_range(0, 10)) - 5);
    end else if (mode >= 75 && mode < 83) begin
      ex = sx;
      ey = sy;
    end else if (mode >= 83 && mode < 91) begin
      d  = int'($urandom_range(0, 12));
      ex = clamp_coord(int'(sx) + ($urandom_range(0, 1) ? d : -d));
      ey = clamp_coord(int'(sy) + ($urandom_range(0, 1) ? d : -d));
    end else if (mode >= 91) begin
      if ($urandom_range(0, 1)) sx = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : '0;
      if ($urandom_range(0, 1)) sy = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : '0;
      if ($urandom_range(0, 1)) ex = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : '0;
      if ($urandom_range(0, 1)) ey = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : '0;
    end
  endtask

  initial begin
    coord_t sx, sy, ex, ey;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines; typed rows carry their own writes
    foreach (DIRECTED[i]) begin
      sender_gap();
      drive_line(DIRECTED[i].sx, DIRECTED[i].sy, DIRECTED[i].ex, DIRECTED[i].ey);
      if (DIRECTED[i].n_typed == 0) begin
        predict_line_writes(DIRECTED[i].sx, DIRECTED[i].sy, DIRECTED[i].ex, DIRECTED[i].ey);
      end else begin
        expected_writes.push_back(DIRECTED[i].typed0);
        if (DIRECTED[i].n_typed == 2) expected_writes.push_back(DIRECTED[i].typed1);
      end
    end
    drain_writes();

    // Random lines; hold off once midway until the block is empty
    for (int unsigned n = 0; n < RANDOM_LINES; n++) begin
      if (n == RANDOM_LINES / 2) drain_writes();
      if (n == RANDOM_LINES - CALM_LINES) calm = 1'b1;
      sender_gap();
      pick_line(sx, sy, ex, ey);
      drive_line(sx, sy, ex, ey);
      predict_line_writes(sx, sy, ex, ey);
    end

    drain_writes();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> antialiased_line_rasterizer.f
sv/acl_pkg.sv
sv/acl_front.sv
sv/acl_fifo.sv
sv/acl_back.sv
sv/antialiased_line_rasterizer.sv
sv/acl_checker.sv
tb/testbench.sv
